FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the sorted set block.
// Needs clk in scope where a macro is used, and rst_n as well for SSET_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SSET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sset_pkg.sv
// Package for the sorted set unit: request and status codes, defaults, cell control.
// No dependencies.
`default_nettype none

package sset_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } sset_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sset_cell.sv
// One storage cell of the sorted set chain: holds an entry, compares it, shifts.
// Depends on sset_pkg.
`default_nettype none

module sset_cell
  import sset_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire sset_ctl_t        ctl,
  input  wire logic             valid,
  input  wire logic [WIDTH-1:0] value,
  input  wire logic             left_lt,
  input  wire logic [WIDTH-1:0] left_entry,
  input  wire logic [WIDTH-1:0] right_entry,
  output logic      [WIDTH-1:0] entry,
  output logic                  lt,
  output logic                  eq
);

  logic [WIDTH-1:0] entry_r;
  logic [WIDTH-1:0] entry_nxt;

  assign entry = entry_r;
  assign lt = valid && ($signed(entry_r) < $signed(value));
  assign eq = valid && (entry_r == value);

  // cells below the sorted place keep their entry; the rest shift
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !lt) begin
      entry_nxt = left_lt ? value : left_entry;
    end else if (ctl.rem && !lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_set_insert_remove_lookup_unit.sv
// Sorted set of up to DEPTH distinct signed WIDTH-bit values in a row of cells. For each
// request every cell compares its entry with the request value at once and the whole
// row shifts up or down in the same cycle, so one beat is accepted per clock while the
// result register is free or being drained. No clearing pass: only the count is reset.
// Depends on sset_pkg and sset_cell.
`default_nettype none

module sorted_set_insert_remove_lookup_unit
  import sset_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // value[31:0], position[36:32], zeros
  input  wire logic [1:0]             in_tuser,  // func[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata  // status[1:0], found[2], count[8:3],
                                                 // read_value[40:9], zeros
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                   accept;
  func_t                  func;
  logic [VALUE_W-1:0]     in_value;
  logic [POS_W-1:0]       in_pos;
  logic [WIDTH-1:0]       value_w;
  sset_ctl_t              ctl;

  logic [WIDTH-1:0]       entry_w [DEPTH];
  logic [DEPTH-1:0]       lt_w, eq_w, valid_w, pos_sel;
  logic                   present, full, pos_ok;
  logic [WIDTH-1:0]       rd_raw;

  status_t                status;
  logic                   found;
  logic [VALUE_W-1:0]     read_value;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = !out_tvalid_r || out_tready;
  assign func     = func_t'(in_tuser);
  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_pos   = in_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign value_w  = WIDTH'(in_value);

  assign present = |eq_w;
  assign full    = (count_r == CW'(DEPTH));
  assign pos_ok  = (32'(in_pos) < 32'(count_r));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_w[i] = (32'(i) < 32'(count_r));
      pos_sel[i] = (32'(in_pos) == 32'(i));
    end
  end

  // position read: and-or select across the row
  always_comb begin
    rd_raw = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_raw = rd_raw | (entry_w[i] & {WIDTH{pos_sel[i]}});
    end
  end

  always_comb begin
    ctl.ins = accept && (func == FUNC_INSERT) && !present && !full;
    ctl.rem = accept && (func == FUNC_REMOVE) && present;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic             left_lt;
      logic [WIDTH-1:0] left_entry;
      logic [WIDTH-1:0] right_entry;
      if (g == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_entry = value_w;
      end else begin : g_mid
        assign left_lt    = lt_w[g-1];
        assign left_entry = entry_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_entry = entry_w[g];
      end else begin : g_inner
        assign right_entry = entry_w[g+1];
      end
      sset_cell #(.WIDTH(WIDTH)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (valid_w[g]),
        .value       (value_w),
        .left_lt     (left_lt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entry_w[g]),
        .lt          (lt_w[g]),
        .eq          (eq_w[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status     = ST_DONE;
    found      = 1'b0;
    read_value = '0;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CW'(1);
    end
    unique case (func)
      FUNC_INSERT: begin
        if (present) begin
          status = ST_NOCHANGE;
          found  = 1'b1;
        end else if (full) begin
          status = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        found = present;
        if (!present) begin
          status = ST_NOCHANGE;
        end
      end
      FUNC_LOOKUP: begin
        found = present;
      end
      FUNC_READ: begin
        if (pos_ok) begin
          read_value = VALUE_W'(rd_raw);
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {7'd0, read_value, COUNT_W'(count_nxt), found, status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: hdl/sset_checker.sv
// Port-level checker for the sorted set unit, bound to the top level.
// Depends on sset_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sset_checker
  import sset_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  logic [1:0]         st;
  logic [COUNT_W-1:0] cnt;
  logic [VALUE_W-1:0] rdv;

  assign st  = out_tdata[1:0];
  assign cnt = out_tdata[8:3];
  assign rdv = out_tdata[40:9];

  `SSET_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result beat after reset")
  `SSET_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `SSET_ASSERT(a_result, in_tvalid && in_tready |=> out_tvalid, "no result for request beat")
  `SSET_ASSERT(a_range_zero, out_tvalid && (st == ST_RANGE) |-> (rdv == '0), "range read data")
  `SSET_ASSERT(a_full_count, out_tvalid && (st == ST_FULL) |-> (cnt == COUNT_W'(DEPTH)), "full count")

endmodule

bind sorted_set_insert_remove_lookup_unit sset_checker #(.DEPTH(DEPTH)) u_sset_checker (.*);

`default_nettype wire
